// ===== hw/rtl/lsbx_pkg.sv =====
package lsbx_pkg;

    localparam int TAG_BYTES = 5;
    localparam int TagBits = TAG_BYTES * 8;
    localparam int TagRegW = 40;
    localparam int CntW = 6;
    localparam int PosW = 32;
    localparam int LenW = 32;
    localparam int ByteW = 8;

    localparam logic [PosW-1:0] OffsetLo = PosW'(10);
    localparam logic [PosW-1:0] OffsetHi = PosW'(13);
    localparam logic [PosW-1:0] MinPixelOffset = PosW'(14);
    localparam logic [CntW-1:0] TagLastBit = CntW'(TagBits - 1);
    localparam logic [CntW-1:0] LenLastBit = CntW'(LenW - 1);
    localparam logic [CntW-1:0] ByteLastBit = CntW'(ByteW - 1);

    typedef enum logic [0:0] {
        REG_TAG_VALUE  = 1'b0,
        REG_CHECK_ONLY = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_TAG    = 3'd2,
        PH_LENGTH = 3'd3,
        PH_TEXT   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD    = 2'd0,
        ST_NO_TAG     = 2'd1,
        ST_TAG_FOUND  = 2'd2,
        ST_EMPTY_TEXT = 2'd3
    } status_t;

    typedef struct packed {
        logic [TagRegW-1:0] tag_value;
        logic               check_only;
    } cfg_t;

    typedef struct packed {
        logic             last;
        status_t          status;
        logic [ByteW-1:0] text_byte;
    } result_t;

endpackage

// ===== hw/rtl/lsbx_parse.sv =====
module lsbx_parse (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     item_valid,
    input  logic [7:0]               image_byte,
    input  logic                     first,
    input  lsbx_pkg::cfg_t           cfg,
    output logic                     res_valid,
    output lsbx_pkg::result_t        res
);
    import lsbx_pkg::*;

    logic [PosW-1:0]    pos_reg, pos_next, pos_cur;
    logic [PosW-1:0]    off_reg, off_next, off_cur, off_hdr;
    phase_t             phase_reg, phase_next, phase_cur;
    logic [CntW-1:0]    bc_reg, bc_next, bc_cur, tag_bc;
    logic [TagBits-1:0] tag_reg, tag_next, tag_cur, tag_src, tag_word, tag_expect;
    logic [LenW-1:0]    len_reg, len_next, len_cur, len_word;
    logic [ByteW-1:0]   byte_reg, byte_next, byte_cur, byte_word;
    logic [LenW-1:0]    left_reg, left_next, left_cur, left_dec;
    logic [1:0]         lane;
    logic               hid_bit;
    logic               tag_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            off_reg   <= '0;
            phase_reg <= PH_HEADER;
            bc_reg    <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            byte_reg  <= '0;
            left_reg  <= '0;
        end else if (item_valid) begin
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            byte_reg  <= byte_next;
            left_reg  <= left_next;
        end
    end

    always_comb begin
        pos_cur   = first ? '0 : pos_reg;
        off_cur   = first ? '0 : off_reg;
        phase_cur = first ? PH_HEADER : phase_reg;
        bc_cur    = first ? '0 : bc_reg;
        tag_cur   = first ? '0 : tag_reg;
        len_cur   = first ? '0 : len_reg;
        byte_cur  = first ? '0 : byte_reg;
        left_cur  = first ? '0 : left_reg;

        hid_bit    = image_byte[0];
        tag_step   = (phase_cur == PH_TAG) ||
                     ((phase_cur == PH_SKIP) && (pos_cur >= off_cur));
        tag_bc     = (phase_cur == PH_SKIP) ? '0 : bc_cur;
        tag_src    = (phase_cur == PH_SKIP) ? '0 : tag_cur;
        tag_word   = {hid_bit, tag_src[TagBits-1:1]};
        tag_expect = TagBits'(cfg.tag_value);
        len_word   = {hid_bit, len_cur[LenW-1:1]};
        byte_word  = {hid_bit, byte_cur[ByteW-1:1]};
        left_dec   = left_cur - LenW'(1);
        lane       = pos_cur[1:0] - 2'd2;
        off_hdr    = off_cur;
        off_hdr[8*lane +: 8] = image_byte;

        pos_next   = (pos_cur == '1) ? pos_cur : pos_cur + PosW'(1);
        off_next   = off_cur;
        phase_next = phase_cur;
        bc_next    = bc_cur;
        tag_next   = tag_cur;
        len_next   = len_cur;
        byte_next  = byte_cur;
        left_next  = left_cur;
        res_valid  = 1'b0;
        res        = '{last: 1'b0, status: ST_PAYLOAD, text_byte: '0};

        unique case (phase_cur)
            PH_HEADER: begin
                if (pos_cur >= OffsetLo && pos_cur <= OffsetHi) begin
                    off_next = off_hdr;
                end
                if (pos_cur == OffsetHi) begin
                    off_next   = (off_hdr < MinPixelOffset) ? MinPixelOffset : off_hdr;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP, PH_TAG: begin
                if (tag_step) begin
                    if (tag_bc != TagLastBit) begin
                        bc_next    = tag_bc + CntW'(1);
                        tag_next   = tag_word;
                        phase_next = PH_TAG;
                    end else begin
                        bc_next  = '0;
                        tag_next = tag_word;
                        if (tag_word != tag_expect) begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res        = '{last: 1'b1, status: ST_NO_TAG, text_byte: '0};
                        end else if (cfg.check_only) begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res        = '{last: 1'b1, status: ST_TAG_FOUND, text_byte: '0};
                        end else begin
                            phase_next = PH_LENGTH;
                            len_next   = '0;
                        end
                    end
                end
            end
            PH_LENGTH: begin
                if (bc_cur != LenLastBit) begin
                    bc_next  = bc_cur + CntW'(1);
                    len_next = len_word;
                end else begin
                    bc_next   = '0;
                    len_next  = len_word;
                    left_next = len_word;
                    if (len_word == '0) begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res        = '{last: 1'b1, status: ST_EMPTY_TEXT, text_byte: '0};
                    end else begin
                        phase_next = PH_TEXT;
                        byte_next  = '0;
                    end
                end
            end
            PH_TEXT: begin
                if (bc_cur != ByteLastBit) begin
                    bc_next   = bc_cur + CntW'(1);
                    byte_next = byte_word;
                end else begin
                    bc_next   = '0;
                    left_next = left_dec;
                    byte_next = '0;
                    res_valid = 1'b1;
                    res       = '{last: (left_dec == '0), status: ST_PAYLOAD,
                                  text_byte: byte_word};
                    if (left_dec == '0) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/lsb_stego_bmp_extractor_unit.sv =====
// Recovers text hidden in the least significant bits of a bitmap file that
// arrives one byte per item, with s_tuser marking byte zero of each file. The
// unit accepts one item every clock cycle while s_tready is high; the result
// is registered in the output register, or in the skid register while the
// output stalls. An item ends in at most one result, and that result is the
// last one for the file unless it is a payload byte with more to follow. The
// header, tag, length and text parser feeds a two-entry output buffer that lets
// input keep flowing while m_tready is low until a second result is waiting.
// The user must write configuration through the plain write port only while no
// file is in flight; the block itself does not enforce this.
module lsb_stego_bmp_extractor_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // image_byte[7:0]
    input  logic [0:0]                 s_tuser,   // first[0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // text_byte[7:0], status[9:8], zero[15:10]
    output logic                       m_tlast,
    input  logic                       cfg_wr_en,
    input  logic [0:0]                 cfg_index,
    input  logic [lsbx_pkg::TagRegW-1:0] cfg_wdata
);
    import lsbx_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_TAG_VALUE:  cfg_reg.tag_value  <= cfg_wdata;
                REG_CHECK_ONLY: cfg_reg.check_only <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    lsbx_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .image_byte (s_tdata),
        .first      (s_tuser[0]),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= accept && res_valid;
            out_reg       <= res;
        end else if (accept && res_valid) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.status, out_reg.text_byte};
    assign m_tlast  = out_reg.last;

endmodule

// ===== hw/rtl/lsbx_checker.sv =====
module lsbx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    import lsbx_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result changed.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Result pending after reset.");

    a_status_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:8] != ST_PAYLOAD) |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("Status result is not a final, empty item.");

    a_stall_buffered: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("Input stalled with no result pending.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("Padding bits of a result are not zero.");

endmodule

bind lsb_stego_bmp_extractor_unit lsbx_checker u_lsbx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
